@@ src/bds_pkg.sv @@
`default_nettype none

package bds_pkg;

    // sizes of the source image that the line store is built for
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // pixel layout
    localparam int NUM_CH    = 4;
    localparam int CH_W      = 8;
    localparam int SUM_W     = CH_W + 1;
    localparam int PIX_W     = NUM_CH * CH_W;
    localparam int CH_RED    = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 2;
    localparam int CH_ALPHA  = 3;

    // configuration registers
    localparam int CFG_DIM_W  = 13;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd2;

    localparam logic [CFG_DIM_W-1:0] RST_SOURCE_WIDTH  = 13'd2;
    localparam logic [CFG_DIM_W-1:0] RST_SOURCE_HEIGHT = 13'd2;
    localparam logic                 RST_PIXEL_FORMAT  = 1'b0;

    localparam logic FMT_RGB  = 1'b0;
    localparam logic FMT_RGBA = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_DIM_W-1:0] width;
        logic [CFG_DIM_W-1:0] height;
        logic                 fmt;
        logic                 restart;
    } cfg_t;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

    // one block to average: pair sum of this row and of the row above
    typedef struct packed {
        sums_t pair_sum;
        sums_t line_sum;
        logic  eor;
        logic  eof;
    } job_t;

endpackage

`default_nettype wire

@@ src/bds_cfg_regs.sv @@
`default_nettype none

module bds_cfg_regs
    import bds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic                 fmt_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic                 sel_width;
    logic                 sel_height;
    logic                 sel_fmt;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // address decode
    always_comb
    begin
        sel_width  = 1'b0;
        sel_height = 1'b0;
        sel_fmt    = 1'b0;
        unique case (reg_idx)
            REG_SOURCE_WIDTH:  sel_width  = 1'b1;
            REG_SOURCE_HEIGHT: sel_height = 1'b1;
            REG_PIXEL_FORMAT:  sel_fmt    = 1'b1;
            default:           sel_width  = 1'b0;
        endcase
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SOURCE_WIDTH;
            height_reg <= RST_SOURCE_HEIGHT;
            fmt_reg    <= RST_PIXEL_FORMAT;
        end
        else if (wr_en)
        begin
            if (sel_width)
                width_reg <= pwdata[CFG_DIM_W-1:0];
            if (sel_height)
                height_reg <= pwdata[CFG_DIM_W-1:0];
            if (sel_fmt)
                fmt_reg <= pwdata[0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (sel_width)
            prdata = APB_DATA_W'(width_reg);
        else if (sel_height)
            prdata = APB_DATA_W'(height_reg);
        else if (sel_fmt)
            prdata = APB_DATA_W'(fmt_reg);
    end

    // any register write starts a new frame
    assign cfg.width   = width_reg;
    assign cfg.height  = height_reg;
    assign cfg.fmt     = fmt_reg;
    assign cfg.restart = wr_en && (sel_width || sel_height || sel_fmt);

endmodule

`default_nettype wire

@@ src/bds_front.sv @@
`default_nettype none

module bds_front
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cfg_t                   cfg,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  s_tdata,
    input  wire logic [QLVL_W-1:0] q_level,
    output logic                   push,
    output job_t                   push_job
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int RCNT_W     = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W      = ($clog2(MAX_DIM + 1) > CFG_DIM_W) ?
                                $clog2(MAX_DIM + 1) : CFG_DIM_W;

    logic [CNT_W-1:0]              col_reg;
    logic [CNT_W-1:0]              col_next;
    logic [RCNT_W-1:0]             row_reg;
    logic [RCNT_W-1:0]             row_next;
    logic [NUM_CH-1:0][CH_W-1:0]   left_reg;
    logic [NUM_CH-1:0][CH_W-1:0]   pix;
    sums_t                         pair_sum;
    sums_t                         line_mem [LINE_DEPTH];
    sums_t                         line_rd_reg;
    sums_t                         s1_pair_reg;
    logic                          s1_emit_reg;
    logic                          s1_eor_reg;
    logic                          s1_eof_reg;
    logic [DIM_W-1:0]              w_raw;
    logic [DIM_W-1:0]              h_raw;
    logic [DIM_W-1:0]              w_clamp;
    logic [DIM_W-1:0]              h_clamp;
    logic [DIM_W-1:0]              col_inc;
    logic [DIM_W-1:0]              row_inc;
    logic                          col_wrap;
    logic                          row_wrap;
    logic                          eor;
    logic                          eof;
    logic                          odd_col;
    logic                          odd_row;
    logic [IDX_W-1:0]              idx;
    logic                          accept;
    logic                          line_wr;
    logic                          line_rd;

    // clamp the frame size to 1..max
    assign w_raw = DIM_W'(cfg.width);
    assign h_raw = DIM_W'(cfg.height);

    always_comb
    begin
        if (w_raw == '0)
            w_clamp = DIM_W'(1);
        else if (w_raw > DIM_W'(MAX_WIDTH))
            w_clamp = DIM_W'(MAX_WIDTH);
        else
            w_clamp = w_raw;
        if (h_raw == '0)
            h_clamp = DIM_W'(1);
        else if (h_raw > DIM_W'(MAX_HEIGHT))
            h_clamp = DIM_W'(MAX_HEIGHT);
        else
            h_clamp = h_raw;
    end

    // position of the incoming pixel
    assign col_inc  = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc  = DIM_W'(row_reg) + DIM_W'(1);
    assign col_wrap = col_inc >= w_clamp;
    assign row_wrap = row_inc >= h_clamp;
    assign eor      = col_inc == (w_clamp & ~DIM_W'(1));
    assign eof      = eor && (row_inc == (h_clamp & ~DIM_W'(1)));
    assign odd_col  = col_reg[0];
    assign odd_row  = row_reg[0];
    assign idx      = col_reg[IDX_W:1];

    // room for this item's block once the pending one is queued
    assign s_tready = ((QLVL_W + 1)'(q_level) + (QLVL_W + 1)'(s1_emit_reg))
                      < (QLVL_W + 1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign line_wr  = accept && odd_col && !odd_row;
    assign line_rd  = accept && odd_col && odd_row;

    // unpack channels, alpha forced to zero in rgb mode
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
            pix[c] = s_tdata[c*CH_W +: CH_W];
        if (cfg.fmt == FMT_RGB)
            pix[CH_ALPHA] = '0;
    end

    // horizontal pair sums
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
            pair_sum[c] = SUM_W'(left_reg[c]) + SUM_W'(pix[c]);
    end

    // column and row counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : RCNT_W'(row_inc);
            end
            else
            begin
                col_next = CNT_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept && !odd_col)
                left_reg <= pix;
        end
    end

    // line store of even-row pair sums
    always_ff @(posedge clk)
    begin
        if (line_wr)
            line_mem[idx] <= pair_sum;
    end

    always_ff @(posedge clk)
    begin
        if (line_rd)
            line_rd_reg <= line_mem[idx];
    end

    // stage that waits for the line store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_emit_reg <= 1'b0;
        else
            s1_emit_reg <= line_rd;
    end

    always_ff @(posedge clk)
    begin
        if (line_rd)
        begin
            s1_pair_reg <= pair_sum;
            s1_eor_reg  <= eor;
            s1_eof_reg  <= eof;
        end
    end

    // job into the queue
    always_comb
    begin
        push              = s1_emit_reg;
        push_job.pair_sum = s1_pair_reg;
        push_job.line_sum = line_rd_reg;
        push_job.eor      = s1_eor_reg;
        push_job.eof      = s1_eof_reg;
        if (cfg.fmt == FMT_RGB)
            push_job.line_sum[CH_ALPHA] = '0;
    end

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_reg) < w_clamp)
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(row_reg) < h_clamp)
        else $error("row counter beyond frame height");

    a_emit_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit_reg |-> $past(line_rd))
        else $error("block emitted without an odd-row pixel");

endmodule

`default_nettype wire

@@ src/bds_queue.sv @@
`default_nettype none

module bds_queue
    import bds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  job_t                   push_job,
    input  wire logic              pop,
    output job_t                   pop_job,
    output logic [QLVL_W-1:0]      level
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QLVL_W-1:0] level_reg;
    logic [QLVL_W-1:0] level_next;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            level_next = level_reg + QLVL_W'(1);
        else if (pop && !push)
            level_next = level_reg - QLVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    assign pop_job = slot_reg[rd_ptr_reg];
    assign level   = level_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg < QLVL_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (level_reg != '0))
        else $error("queue read while empty");

    a_level_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (level_reg == QLVL_W'($past(level_reg) + QLVL_W'(1))))
        else $error("queue level lost a pushed item");

endmodule

`default_nettype wire

@@ src/bds_back.sv @@
`default_nettype none

module bds_back
    import bds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [QLVL_W-1:0] q_level,
    input  job_t                   pop_job,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [PIX_W-1:0]       m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    logic                        out_valid_reg;
    logic [NUM_CH-1:0][CH_W-1:0] out_pix_reg;
    logic                        out_eor_reg;
    logic                        out_eof_reg;
    logic [NUM_CH-1:0][CH_W-1:0] avg;
    logic [NUM_CH-1:0][SUM_W:0]  quad_sum;

    // take a job when the output register is free or being drained
    assign pop = (q_level != '0) && (!out_valid_reg || m_tready);

    // sum of four, divided by four
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            quad_sum[c] = (SUM_W + 1)'(pop_job.pair_sum[c])
                        + (SUM_W + 1)'(pop_job.line_sum[c]);
            avg[c]      = quad_sum[c][SUM_W:2];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_pix_reg <= avg;
            out_eor_reg <= pop_job.eor;
            out_eof_reg <= pop_job.eof;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_eor_reg;
    assign m_tuser  = out_eof_reg;

endmodule

`default_nettype wire

@@ src/box_downsample_2x2_core.sv @@
// channel   dir  width  fields (low bit first)
// s_axis    in   32     tdata: red_in, green_in, blue_in, alpha_in
// m_axis    out  32+2   tdata: red_out, green_out, blue_out, alpha_out;
//                       tlast: end_of_row; tuser: end_of_frame
// apb       in   4/32   source_width @0, source_height @4, pixel_format @8
//
// one source pixel per clock while s_tready is high; after the bottom-right pixel of its
// block a result passes the line store read, the queue and the output register
// the line store is one 36-bit word per source column pair, one write or
// one read per clock, so it sets the one pixel per clock figure
// reset is asynchronous; the line store needs no clearing pass
// input stalls only when the queued blocks and the pending block fill the four-entry queue
`default_nettype none

module box_downsample_2x2_core
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // source pixels
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in, alpha_in
    // averaged pixels
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [PIX_W-1:0]           m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic                       m_tlast,   // end_of_row
    output logic                       m_tuser,   // end_of_frame
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t              cfg;
    logic              push;
    job_t              push_job;
    logic              pop;
    job_t              pop_job;
    logic [QLVL_W-1:0] q_level;

    // configuration registers
    bds_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // counters, pair sums and line store
    bds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_level  (q_level),
        .push     (push),
        .push_job (push_job)
    );

    // blocks waiting to be averaged
    bds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .level    (q_level)
    );

    // averaging and output register
    bds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_level  (q_level),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ tb/sv/box_downsample_2x2_core_test.sv @@
`default_nettype none

module box_downsample_2x2_core_test;
    import bds_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PERCENT   = 28;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 880;
    localparam int PRINT_LIMIT    = 40;
    localparam int LINE_PAIRS     = DEF_MAX_WIDTH / 2;

    // address with no register behind it
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t channels;
        logic   row_end;
        logic   frame_end;
    } box_mean_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata  = '0;    // red_in, green_in, blue_in, alpha_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIX_W-1:0]      m_tdata;          // red_out, green_out, blue_out, alpha_out
    logic                  m_tlast;          // end_of_row
    logic                  m_tuser;          // end_of_frame
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // stimulus and expected averages
    pixel_t    pixel_queue[$];
    box_mean_t expected_means[$];

    // shadow of the block's registers and state
    logic [CFG_DIM_W-1:0] src_width  = RST_SOURCE_WIDTH;
    logic [CFG_DIM_W-1:0] src_height = RST_SOURCE_HEIGHT;
    logic                 pix_fmt    = RST_PIXEL_FORMAT;
    sums_t                pair_sum_store [LINE_PAIRS];
    pixel_t               left_hold  = '0;
    int unsigned          col_pos    = 0;
    int unsigned          row_pos    = 0;

    bit    calm          = 1'b0;
    int    hold_requests = 0;
    int    holds_served  = 0;
    int    hold_left     = 0;
    int    quiet_cycles  = 0;
    int    results_seen  = 0;
    int    mismatch_count = 0;
    string channel_names [NUM_CH] = '{"red_out", "green_out", "blue_out", "alpha_out"};

    box_downsample_2x2_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF clk = ~clk;

    // zero counts as one, oversize saturates
    function automatic int unsigned clamp_size(input logic [CFG_DIM_W-1:0] v,
                                               input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // bytes mostly random, now and then forced to an extreme
    function automatic pixel_t random_pixel();
        pixel_t p;
        p = $urandom;
        for (int c = 0; c < NUM_CH; c++)
        begin
            case ($urandom_range(0, 7))
                0: p[c] = '0;
                1: p[c] = '1;
                default: ;
            endcase
        end
        return p;
    endfunction

    // advance the shadow state by one source pixel, queue the average if one is due
    task automatic predict_pixel(input pixel_t pix);
        int unsigned    w;
        int unsigned    h;
        int unsigned    col;
        int unsigned    row;
        pixel_t         px;
        sums_t          sums;
        sums_t          above;
        logic [SUM_W:0] total;
        box_mean_t      mean;
        w   = clamp_size(src_width, DEF_MAX_WIDTH);
        h   = clamp_size(src_height, DEF_MAX_HEIGHT);
        col = (col_pos >= w) ? w - 1 : col_pos;
        row = (row_pos >= h) ? h - 1 : row_pos;
        px  = pix;
        if (pix_fmt == FMT_RGB)
            px[CH_ALPHA] = '0;

        if (col[0] == 1'b0)
            left_hold = px;
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
                sums[c] = SUM_W'(left_hold[c]) + SUM_W'(px[c]);
            if (row[0] == 1'b0)
                pair_sum_store[col >> 1] = sums;
            else
            begin
                above = pair_sum_store[col >> 1];
                for (int c = 0; c < NUM_CH; c++)
                begin
                    total = (SUM_W + 1)'(sums[c]) + (SUM_W + 1)'(above[c]);
                    mean.channels[c] = total[SUM_W:2];
                end
                if (pix_fmt == FMT_RGB)
                    mean.channels[CH_ALPHA] = '0;
                mean.row_end   = (col + 1 == (w / 2) * 2);
                mean.frame_end = mean.row_end && (row + 1 == (h / 2) * 2);
                expected_means.push_back(mean);
            end
        end

        // raster counters wrap at the end of the frame
        if (col + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end
        else
        begin
            col_pos = col + 1;
            row_pos = row;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
        mismatch_count++;
    endtask

    // setup and access cycle, then mirror the write
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  src_width  = value[CFG_DIM_W-1:0];
            REG_SOURCE_HEIGHT: src_height = value[CFG_DIM_W-1:0];
            REG_PIXEL_FORMAT:  pix_fmt    = value[0];
            default:           return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    // all three registers, upper bits optionally filled with junk
    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input logic fmt, input bit noisy);
        logic [APB_DATA_W-1:0] value;
        value = noisy ? $urandom : '0;
        value[CFG_DIM_W-1:0] = w[CFG_DIM_W-1:0];
        write_reg(REG_SOURCE_WIDTH, value);
        value = noisy ? $urandom : '0;
        value[CFG_DIM_W-1:0] = h[CFG_DIM_W-1:0];
        write_reg(REG_SOURCE_HEIGHT, value);
        value = noisy ? $urandom : '0;
        value[0] = fmt;
        write_reg(REG_PIXEL_FORMAT, value);
    endtask

    task automatic feed_random(input int unsigned count);
        repeat (count)
            pixel_queue.push_back(random_pixel());
    endtask

    // wait until every item is in and every average is out, then let the pipe empty
    task automatic settle();
        while (pixel_queue.size() != 0 || s_tvalid || expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // source side: offer queued pixels, predict on each accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pixel_queue.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_queue.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result side: random backpressure, long hold-offs on request, compare
    always @(posedge clk or negedge rst_n)
    begin : receive_side
        box_mean_t want;
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_means.size() == 0)
                    report_mismatch("unexpected item", m_tdata, '0);
                else
                begin
                    want = expected_means.pop_front();
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        if (m_tdata[c*CH_W +: CH_W] !== want.channels[c])
                            report_mismatch(channel_names[c], m_tdata[c*CH_W +: CH_W],
                                            want.channels[c]);
                    end
                    if (m_tlast !== want.row_end)
                        report_mismatch("end_of_row", m_tlast, want.row_end);
                    if (m_tuser !== want.frame_end)
                        report_mismatch("end_of_frame", m_tuser, want.frame_end);
                end
            end

            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served <= holds_served + 1;
                hold_left    <= HOLD_CYCLES;
                m_tready     <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // give up after a long run of cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("** box_downsample_2x2_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int unsigned random_items;
        random_items = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset geometry 2x2 rgb: full-scale block with alpha ignored,
        // then a block whose sums truncate to zero
        repeat (4) pixel_queue.push_back('1);
        pixel_queue.push_back(32'h00000000);
        pixel_queue.push_back(32'h03030303);
        pixel_queue.push_back(32'h00000000);
        pixel_queue.push_back(32'h00000000);
        settle();

        // odd width and height: last column and last row dropped
        set_frame(3, 3, FMT_RGBA, 1'b0);
        pixel_queue.push_back(32'hFF00FF00);
        pixel_queue.push_back(32'h00FF00FF);
        pixel_queue.push_back(32'h12345678);
        pixel_queue.push_back(32'hFFFFFFFF);
        pixel_queue.push_back(32'h80808080);
        pixel_queue.push_back(32'hDEADBEEF);
        repeat (3) pixel_queue.push_back(32'h7F7F7F7F);
        settle();

        // zero sizes act as one: nothing comes out
        set_frame(0, 0, FMT_RGBA, 1'b0);
        feed_random(3);
        settle();

        // alternating extremes; a write to the spare address keeps the frame going
        set_frame(4, 2, FMT_RGBA, 1'b0);
        repeat (2)
        begin
            pixel_queue.push_back(32'h00FF00FF);
            pixel_queue.push_back(32'hFF00FF00);
        end
        settle();
        write_reg(REG_SPARE, $urandom);
        repeat (2)
        begin
            pixel_queue.push_back(32'hFF00FF00);
            pixel_queue.push_back(32'h00FF00FF);
        end
        settle();

        // oversize sizes saturate and a zero height acts as one; short runs into the first rows
        set_frame(8191, DEF_MAX_HEIGHT, FMT_RGB, 1'b0);
        feed_random(40);
        settle();
        set_frame(DEF_MAX_WIDTH, 0, FMT_RGBA, 1'b0);
        feed_random(20);
        settle();
        set_frame(2, 8191, FMT_RGBA, 1'b0);
        feed_random(24);
        settle();

        // receiver holds off while the source keeps offering
        set_frame(6, 8, FMT_RGBA, 1'b1);
        hold_requests++;
        feed_random(144);
        settle();

        // random geometries: mostly whole frames, some cut short
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 3);
                count = w * h;
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                count = w * h * $urandom_range(1, 3);
            end
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, count);
            set_frame(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            calm = (random_items >= 300 && random_items < 600);
            feed_random(count);
            random_items += count;
            settle();
        end
        calm = 1'b0;
        settle();

        if (mismatch_count == 0 && expected_means.size() == 0)
            $display("** box_downsample_2x2_core: PASSED **");
        else
            $display("** box_downsample_2x2_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

@@ box_downsample_2x2_core.f @@
src/bds_pkg.sv
src/bds_cfg_regs.sv
src/bds_front.sv
src/bds_queue.sv
src/bds_back.sv
src/box_downsample_2x2_core.sv
tb/sv/box_downsample_2x2_core_test.sv
